// ----- src/ewma_lrv_pkg.sv -----
// Shared types and constants for the EWMA log-return variance block.
`default_nettype none

package ewma_lrv_pkg;

  localparam int unsigned MulOpW   = 64;
  localparam int unsigned MulProdW = 128;
  localparam int unsigned DivNumW  = 128;
  localparam int unsigned DivDenW  = 64;

  localparam logic [62:0] VAR_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
  localparam logic [31:0] LN2_Q32   = 32'hB172_17F8;
  localparam logic [31:0] NS_PER_S  = 32'd1_000_000_000;
  localparam logic [31:0] NS_PER_US = 32'd1000;
  localparam logic [31:0] HL_RESET  = 32'd1_000_000;
  // Reciprocals for exact floor division by 6 and 24 of the small Taylor terms.
  localparam logic [31:0] RECIP6    = 32'd715_827_883;
  localparam logic [31:0] RECIP24   = 32'd178_956_971;
  localparam int unsigned LogFrac   = 26;
  localparam int unsigned ExpSquares = 16;

  typedef struct packed {
    logic        cmd;
    logic [31:0] mid_price;
    logic [62:0] timestamp_ns;
  } in_t;

  typedef struct packed {
    logic [62:0] variance;
    logic [31:0] sample_count;
    logic        updated;
  } out_t;

  typedef struct packed {
    logic                start;
    logic [MulOpW-1:0]   a;
    logic [MulOpW-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                done;
    logic [MulProdW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] n;
    logic [DivDenW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] q;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/ewma_lrv_mul.sv -----
// 64x64 multiplier built from one 32x32 multiplier, reused for each partial product.
`default_nettype none

module ewma_lrv_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ewma_lrv_pkg::mul_req_t req_i,
  output ewma_lrv_pkg::mul_rsp_t rsp_o
);

  logic [63:0]  a_q, b_q;
  logic [127:0] acc_q;
  logic [1:0]   step_q;
  logic         busy_q, done_q;
  logic [31:0]  x, y;
  logic [63:0]  pp;
  logic [127:0] term;

  always_comb begin
    x    = a_q[31:0];
    y    = b_q[31:0];
    case (step_q)
      2'd0: begin x = a_q[31:0];  y = b_q[31:0];  end
      2'd1: begin x = a_q[31:0];  y = b_q[63:32]; end
      2'd2: begin x = a_q[63:32]; y = b_q[31:0];  end
      default: begin x = a_q[63:32]; y = b_q[63:32]; end
    endcase
    pp = 64'(x) * 64'(y);
    case (step_q)
      2'd0:    term = 128'(pp);
      2'd3:    term = 128'(pp) << 64;
      default: term = 128'(pp) << 32;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        acc_q  <= '0;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q  <= acc_q + term;
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

`default_nettype wire

// ----- src/ewma_lrv_div.sv -----
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit a cycle.
`default_nettype none

module ewma_lrv_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ewma_lrv_pkg::div_req_t req_i,
  output ewma_lrv_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NumW = ewma_lrv_pkg::DivNumW;
  localparam int unsigned DenW = ewma_lrv_pkg::DivDenW;
  localparam int unsigned CntW = $clog2(NumW);

  logic [NumW-1:0] n_q, q_q;
  logic [DenW-1:0] d_q, rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW-1:0] rem_x;
  logic            ge;

  // The divisor stays below 2^63, so the shifted remainder always fits.
  assign rem_x = {rem_q[DenW-2:0], n_q[NumW-1]};
  assign ge    = (rem_x >= d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      q_q    <= '0;
      d_q    <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        n_q    <= req_i.n;
        d_q    <= req_i.d;
        q_q    <= '0;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        n_q   <= n_q << 1;
        rem_q <= ge ? (rem_x - d_q) : rem_x;
        q_q   <= {q_q[NumW-2:0], ge};
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;

endmodule

`default_nettype wire

// ----- src/ewma_log_return_variance_top.sv -----
// Top level: sequencer that drives the shared multiplier and divider.
`default_nettype none

// Each price item is compared with the stored last price; when one exists and
// time has moved forward, the squared log return per second is blended into
// the smoothed variance with a decay set by the half-life in microseconds
// (hl_q). The block takes one item at a time and raises in_ready_o only when
// idle. A clear item, one that blends nothing, or one with a zero mid price
// goes straight to the output state. When the decay exponent reaches 32 the
// exponential is skipped. The 79 products of a full update (58 when skipped),
// among them two 26-step log2 squarings, run one after another on the shared
// 4-step 64x64 multiplier, and the two 128-step restoring divisions run on
// one divider.
// The result waits in an output register, and the next item is taken once it
// has been loaded there.
module ewma_log_return_variance_top #(
  parameter int unsigned VALUE_FRAC_BITS = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ewma_lrv_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ewma_lrv_pkg::out_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i
);

  localparam int unsigned NumShl = (VALUE_FRAC_BITS > 52) ? VALUE_FRAC_BITS - 52 : 0;
  localparam int unsigned QShr   = (VALUE_FRAC_BITS < 52) ? 52 - VALUE_FRAC_BITS : 0;

  typedef enum logic [17:0] {
    ST_IDLE   = 18'h00001,
    ST_DECIDE = 18'h00002,
    ST_LOG    = 18'h00004,
    ST_LN     = 18'h00008,
    ST_SQ     = 18'h00010,
    ST_NUM    = 18'h00020,
    ST_RDIV   = 18'h00040,
    ST_HMUL   = 18'h00080,
    ST_XDIV   = 18'h00100,
    ST_T2     = 18'h00200,
    ST_T3     = 18'h00400,
    ST_T4     = 18'h00800,
    ST_D6     = 18'h01000,
    ST_D24    = 18'h02000,
    ST_ESQ    = 18'h04000,
    ST_BL1    = 18'h08000,
    ST_BL2    = 18'h10000,
    ST_OUT    = 18'h20000
  } state_e;

  function automatic logic [4:0] msb_pos(input logic [31:0] n);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (n[i]) p = 5'(i);
    end
    return p;
  endfunction

  state_e                 state_q;
  ewma_lrv_pkg::in_t      item_q;
  ewma_lrv_pkg::out_t     out_q;
  logic                   out_valid_q;
  logic [31:0]            hl_q;
  logic [62:0]            var_q, last_time_q, dt_q, r_q;
  logic [31:0]            cnt_q, last_price_q;
  logic                   upd_q;
  logic [25:0]            frac_q;
  logic [4:0]             exp_q, it_q;
  logic                   which_q;
  logic [30:0]            lm_q;
  logic [63:0]            t_q, t3_q, t4_q, acc_q;
  logic [32:0]            lam_q;
  logic [127:0]           p1_q;
  ewma_lrv_pkg::mul_req_t mul_req_q;
  ewma_lrv_pkg::mul_rsp_t mul_rsp;
  ewma_lrv_pkg::div_req_t div_req_q;
  ewma_lrv_pkg::div_rsp_t div_rsp;

  logic [127:0] mul_p;
  logic [63:0]  p62, p32;
  logic [31:0]  cnt_inc, hl_eff;
  logic [4:0]   mid_msb, last_msb;
  logic [31:0]  mid_norm, last_norm;
  logic [32:0]  log_mm;
  logic         log_bit;
  logic [31:0]  log_m;
  logic [25:0]  log_frac;
  logic [30:0]  log_res, log_diff;
  logic [127:0] qs, bl_sum;
  logic [63:0]  e_sum;

  ewma_lrv_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .rsp_o  (mul_rsp)
  );

  ewma_lrv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    mul_p     = mul_rsp.p;
    p62       = mul_p[125:62];
    p32       = mul_p[95:32];
    cnt_inc   = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
    hl_eff    = (hl_q == '0) ? 32'd1 : hl_q;
    mid_msb   = msb_pos(item_q.mid_price);
    last_msb  = msb_pos(last_price_q);
    mid_norm  = item_q.mid_price << (5'd31 - mid_msb);
    last_norm = last_price_q << (5'd31 - last_msb);
    // One squaring step of the mantissa yields one fraction bit of log2.
    log_mm    = mul_p[63:31];
    log_bit   = log_mm[32];
    log_m     = log_bit ? log_mm[32:1] : log_mm[31:0];
    log_frac  = {frac_q[24:0], log_bit};
    log_res   = {exp_q, log_frac};
    log_diff  = (lm_q >= log_res) ? (lm_q - log_res) : (log_res - lm_q);
    qs        = div_rsp.q >> QShr;
    bl_sum    = p1_q + mul_p;
    e_sum     = acc_q + p32;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_q       <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      hl_q         <= ewma_lrv_pkg::HL_RESET;
      var_q        <= '0;
      cnt_q        <= '0;
      last_price_q <= '0;
      last_time_q  <= '0;
      dt_q         <= '0;
      r_q          <= '0;
      upd_q        <= 1'b0;
      frac_q       <= '0;
      exp_q        <= '0;
      it_q         <= '0;
      which_q      <= 1'b0;
      lm_q         <= '0;
      t_q          <= '0;
      t3_q         <= '0;
      t4_q         <= '0;
      acc_q        <= '0;
      lam_q        <= '0;
      p1_q         <= '0;
      mul_req_q    <= '0;
      div_req_q    <= '0;
    end else begin
      mul_req_q.start <= 1'b0;
      div_req_q.start <= 1'b0;
      if (cfg_we_i) hl_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          upd_q <= 1'b0;
          if (item_q.cmd) begin
            var_q        <= '0;
            cnt_q        <= '0;
            last_price_q <= '0;
            last_time_q  <= '0;
            state_q      <= ST_OUT;
          end else if (last_price_q != '0 && item_q.timestamp_ns > last_time_q) begin
            dt_q <= item_q.timestamp_ns - last_time_q;
            if (item_q.mid_price == '0) begin
              // Infinite return: the variance pins at its maximum.
              var_q   <= ewma_lrv_pkg::VAR_MAX;
              cnt_q   <= cnt_inc;
              upd_q   <= 1'b1;
              state_q <= ST_OUT;
            end else begin
              exp_q           <= mid_msb;
              frac_q          <= '0;
              it_q            <= '0;
              which_q         <= 1'b0;
              mul_req_q.start <= 1'b1;
              mul_req_q.a     <= 64'(mid_norm);
              mul_req_q.b     <= 64'(mid_norm);
              state_q         <= ST_LOG;
            end
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_LOG: begin
          if (mul_rsp.done) begin
            if (it_q == 5'(ewma_lrv_pkg::LogFrac - 1)) begin
              if (!which_q) begin
                lm_q            <= log_res;
                which_q         <= 1'b1;
                it_q            <= '0;
                frac_q          <= '0;
                exp_q           <= last_msb;
                mul_req_q.start <= 1'b1;
                mul_req_q.a     <= 64'(last_norm);
                mul_req_q.b     <= 64'(last_norm);
              end else begin
                mul_req_q.start <= 1'b1;
                mul_req_q.a     <= 64'(log_diff);
                mul_req_q.b     <= 64'(ewma_lrv_pkg::LN2_Q32);
                state_q         <= ST_LN;
              end
            end else begin
              frac_q          <= log_frac;
              it_q            <= it_q + 5'd1;
              mul_req_q.start <= 1'b1;
              mul_req_q.a     <= 64'(log_m);
              mul_req_q.b     <= 64'(log_m);
            end
          end
        end
        ST_LN: begin
          if (mul_rsp.done) begin
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= 64'(mul_p[62:32]);
            mul_req_q.b     <= 64'(mul_p[62:32]);
            state_q         <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (mul_rsp.done) begin
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= 64'(mul_p[61:0]);
            mul_req_q.b     <= 64'(ewma_lrv_pkg::NS_PER_S);
            state_q         <= ST_NUM;
          end
        end
        ST_NUM: begin
          if (mul_rsp.done) begin
            div_req_q.start <= 1'b1;
            div_req_q.n     <= mul_p << NumShl;
            div_req_q.d     <= 64'(dt_q);
            state_q         <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (div_rsp.done) begin
            r_q             <= (qs[127:63] != '0) ? ewma_lrv_pkg::VAR_MAX : qs[62:0];
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= 64'(hl_eff);
            mul_req_q.b     <= 64'(ewma_lrv_pkg::NS_PER_US);
            state_q         <= ST_HMUL;
          end
        end
        ST_HMUL: begin
          if (mul_rsp.done) begin
            div_req_q.start <= 1'b1;
            div_req_q.n     <= 128'(dt_q) << 32;
            div_req_q.d     <= mul_p[63:0];
            state_q         <= ST_XDIV;
          end
        end
        ST_XDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.q[127:37] != '0) begin
              // Decay exponent of 32 or more: the old average is dropped.
              lam_q           <= '0;
              mul_req_q.start <= 1'b1;
              mul_req_q.a     <= '0;
              mul_req_q.b     <= 64'(var_q);
              state_q         <= ST_BL1;
            end else begin
              t_q             <= 64'({div_rsp.q[36:0], 14'b0});
              mul_req_q.start <= 1'b1;
              mul_req_q.a     <= 64'({div_rsp.q[36:0], 14'b0});
              mul_req_q.b     <= 64'({div_rsp.q[36:0], 14'b0});
              state_q         <= ST_T2;
            end
          end
        end
        ST_T2: begin
          if (mul_rsp.done) begin
            acc_q           <= ewma_lrv_pkg::ONE_Q62 - t_q + (p62 >> 1);
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= p62;
            mul_req_q.b     <= t_q;
            state_q         <= ST_T3;
          end
        end
        ST_T3: begin
          if (mul_rsp.done) begin
            t3_q            <= p62;
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= p62;
            mul_req_q.b     <= t_q;
            state_q         <= ST_T4;
          end
        end
        ST_T4: begin
          if (mul_rsp.done) begin
            t4_q            <= p62;
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= t3_q;
            mul_req_q.b     <= 64'(ewma_lrv_pkg::RECIP6);
            state_q         <= ST_D6;
          end
        end
        ST_D6: begin
          if (mul_rsp.done) begin
            acc_q           <= acc_q - p32;
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= t4_q;
            mul_req_q.b     <= 64'(ewma_lrv_pkg::RECIP24);
            state_q         <= ST_D24;
          end
        end
        ST_D24: begin
          if (mul_rsp.done) begin
            acc_q           <= e_sum;
            it_q            <= '0;
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= e_sum;
            mul_req_q.b     <= e_sum;
            state_q         <= ST_ESQ;
          end
        end
        ST_ESQ: begin
          if (mul_rsp.done) begin
            if (it_q == 5'(ewma_lrv_pkg::ExpSquares - 1)) begin
              lam_q           <= p62[62:30];
              mul_req_q.start <= 1'b1;
              mul_req_q.a     <= 64'(p62[62:30]);
              mul_req_q.b     <= 64'(var_q);
              state_q         <= ST_BL1;
            end else begin
              acc_q           <= p62;
              it_q            <= it_q + 5'd1;
              mul_req_q.start <= 1'b1;
              mul_req_q.a     <= p62;
              mul_req_q.b     <= p62;
            end
          end
        end
        ST_BL1: begin
          if (mul_rsp.done) begin
            p1_q            <= mul_p;
            mul_req_q.start <= 1'b1;
            mul_req_q.a     <= 64'(33'h1_0000_0000 - lam_q);
            mul_req_q.b     <= 64'(r_q);
            state_q         <= ST_BL2;
          end
        end
        ST_BL2: begin
          if (mul_rsp.done) begin
            var_q   <= bl_sum[94:32];
            cnt_q   <= cnt_inc;
            upd_q   <= 1'b1;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.variance     <= var_q;
            out_q.sample_count <= cnt_q;
            out_q.updated      <= upd_q;
            out_valid_q        <= 1'b1;
            if (!item_q.cmd) begin
              last_price_q <= item_q.mid_price;
              last_time_q  <= item_q.timestamp_ns;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
